/* hw/rtl/bilinear_wrap_texture_sampler_unit_assert.svh */
// assertion macros for the texture sampler top level
// expects clk and rst in the scope of each use
`ifndef BILINEAR_WRAP_TEXTURE_SAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_WRAP_TEXTURE_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication
`define BWTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bwts check failed");

// next-cycle implication
`define BWTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bwts check failed");

`endif

/* hw/rtl/bwts_pkg.sv */
// shared types, constants and helpers for the texture sampler
// no dependencies
package bwts_pkg;

  localparam int MAX_DIM    = 256;
  localparam int CHAN_BITS  = 12;
  localparam int FRAC_BITS  = 8;
  localparam int COORD_BITS = 24;
  localparam int PIX_BITS   = 8;
  localparam int DIM_BITS   = 9;
  localparam int ADDR_BITS  = 16;
  localparam int INT_BITS   = COORD_BITS - FRAC_BITS;
  localparam int LERP_W     = CHAN_BITS + FRAC_BITS;
  localparam int SUM_W      = CHAN_BITS + 2 * FRAC_BITS;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]                   op;
    logic [PIX_BITS-1:0]          pix_x;
    logic [PIX_BITS-1:0]          pix_y;
    logic [CHAN_BITS-1:0]         red_in;
    logic [CHAN_BITS-1:0]         green_in;
    logic [CHAN_BITS-1:0]         blue_in;
    logic signed [COORD_BITS-1:0] sample_x;
    logic signed [COORD_BITS-1:0] sample_y;
  } cmd_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red_out;
    logic [CHAN_BITS-1:0] green_out;
    logic [CHAN_BITS-1:0] blue_out;
  } result_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] r;
    logic [CHAN_BITS-1:0] g;
    logic [CHAN_BITS-1:0] b;
  } pix_t;

  typedef struct packed {
    logic                       start;
    logic signed [INT_BITS-1:0] value;
    logic [DIM_BITS-1:0]        divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [PIX_BITS-1:0] rem;
  } mod_rsp_t;

  function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] d);
    logic [DIM_BITS-1:0] r;
    if (d == '0) r = DIM_BITS'(1);
    else if (d > DIM_BITS'(MAX_DIM)) r = DIM_BITS'(MAX_DIM);
    else r = d;
    return r;
  endfunction

  function automatic logic [CHAN_BITS-1:0] chan_of(input pix_t p, input logic [1:0] c);
    logic [CHAN_BITS-1:0] v;
    case (c)
      2'd0:    v = p.r;
      2'd1:    v = p.g;
      default: v = p.b;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/bwts_mod.sv */
// iterative floor-modulo unit, one remainder bit per cycle
// depends on bwts_pkg
module bwts_mod (
  input  logic              clk,
  input  logic              rst,
  input  bwts_pkg::mod_req_t req,
  output bwts_pkg::mod_rsp_t rsp
);
  import bwts_pkg::*;

  localparam int CNT_W = $clog2(INT_BITS + 1);

  logic [INT_BITS-1:0] mag;
  logic [DIM_BITS-1:0] rem;
  logic [DIM_BITS-1:0] div;
  logic [CNT_W-1:0]    cnt;
  logic                run;
  logic                neg;
  logic                done;
  logic [DIM_BITS:0]   trial;
  logic [DIM_BITS-1:0] rem_next;
  logic [DIM_BITS-1:0] fin;

  always_comb begin
    trial = {rem, mag[INT_BITS-1]};
    if (trial >= {1'b0, div}) rem_next = DIM_BITS'(trial - {1'b0, div});
    else rem_next = trial[DIM_BITS-1:0];
    if (neg && rem != '0) fin = div - rem;
    else fin = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
        neg <= req.value[INT_BITS-1];
        mag <= req.value[INT_BITS-1] ? INT_BITS'(-req.value) : INT_BITS'(req.value);
        rem <= '0;
        div <= req.divisor;
      end else if (run) begin
        rem <= rem_next;
        mag <= {mag[INT_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(INT_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = fin[PIX_BITS-1:0];

endmodule

/* hw/rtl/bwts_lerp.sv */
// registered linear blend a*(1-f) + b*f, shared by all blend steps
// depends on bwts_pkg
module bwts_lerp (
  input  logic                           clk,
  input  logic [bwts_pkg::LERP_W-1:0]    a,
  input  logic [bwts_pkg::LERP_W-1:0]    b,
  input  logic [bwts_pkg::FRAC_BITS-1:0] f,
  output logic [bwts_pkg::SUM_W-1:0]     sum
);
  import bwts_pkg::*;

  logic [FRAC_BITS:0]          one_minus;
  logic [LERP_W+FRAC_BITS:0]   pa;
  logic [LERP_W+FRAC_BITS:0]   pb;
  logic [LERP_W+FRAC_BITS+1:0] tot;

  always_comb begin
    one_minus = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, f};
    pa  = (LERP_W+FRAC_BITS+1)'(a * one_minus);
    pb  = (LERP_W+FRAC_BITS+1)'(b * {1'b0, f});
    tot = {1'b0, pa} + {1'b0, pb};
  end

  always_ff @(posedge clk) begin
    sum <= tot[SUM_W-1:0];
  end

endmodule

/* hw/rtl/bwts_store.sv */
// single-port pixel memory with registered read data
// depends on bwts_pkg
module bwts_store (
  input  logic                           clk,
  input  logic                           we,
  input  logic [bwts_pkg::ADDR_BITS-1:0] addr,
  input  bwts_pkg::pix_t                 wdata,
  output bwts_pkg::pix_t                 rdata
);
  import bwts_pkg::*;

  pix_t mem [0:(1 << ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    else rdata <= mem[addr];
  end

endmodule

/* hw/rtl/bilinear_wrap_texture_sampler_unit.sv */
// bilinear wrap texture sampler, top level with sequencer
// depends on bwts_pkg, bwts_mod, bwts_lerp, bwts_store and the assert header
//
// usage: a command word is taken when start is high and busy is low.
// op write stores one pixel and gives no result.
// op point read returns the stored pixel through the read state, then done
// pulses in the done state. op sample wraps the floored coordinates with
// the iterative modulo unit, x first and then y, reads four texels through
// the single memory port and blends them with one shared blend unit; done
// then pulses in the done state. op 3 is dropped at once.
// each result word is marked by done; the receiver cannot stall, so no
// buffering is needed. busy stays high until the cycle after done.
// the config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is image width, index 1 image height; write it while idle.
// reset sets both dimensions to 256; the pixel memory is not cleared and
// unwritten texels read as unknown.
`include "bilinear_wrap_texture_sampler_unit_assert.svh"
module bilinear_wrap_texture_sampler_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bwts_pkg::cmd_t                cmd,
  output logic                          done,
  output bwts_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [bwts_pkg::DIM_BITS-1:0] cfg_data
);
  import bwts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_MODX = 3'd2;
  localparam logic [2:0] S_MODY = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_LERP = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]           state;
  logic [DIM_BITS-1:0]  img_width;
  logic [DIM_BITS-1:0]  img_height;
  logic [DIM_BITS-1:0]  w_eff;
  logic [DIM_BITS-1:0]  h_eff;
  cmd_t                 cmd_q;
  logic [PIX_BITS-1:0]  x0, x1, y0, y1;
  logic [2:0]           k;
  logic [2:0]           nreads;
  pix_t                 tex [0:3];
  logic                 mod_go;
  mod_req_t             mod_req;
  mod_rsp_t             mod_rsp;
  logic [1:0]           chan;
  logic [1:0]           ph;
  logic                 lv;
  logic [1:0]           last_chan;
  logic [1:0]           last_ph;
  logic [LERP_W-1:0]    top;
  logic [CHAN_BITS-1:0] res [0:2];
  logic [LERP_W-1:0]    la, lb;
  logic [FRAC_BITS-1:0] lf;
  logic [SUM_W-1:0]     lsum;
  logic [SUM_W:0]       rnd;
  logic [PIX_BITS-1:0]  ax, ay;
  logic [ADDR_BITS:0]   prod;
  logic [ADDR_BITS-1:0] addr;
  logic                 we;
  pix_t                 wdata;
  pix_t                 rdata;
  logic [DIM_BITS-1:0]  inc;
  logic [DIM_BITS-1:0]  dim_sel;

  assign w_eff     = eff_dim(img_width);
  assign h_eff     = eff_dim(img_height);
  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign nreads    = (cmd_q.op == OP_SAMPLE) ? 3'd4 : 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= DIM_BITS'(MAX_DIM);
      img_height <= DIM_BITS'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH) img_width <= cfg_data;
      else img_height <= cfg_data;
    end
  end

  // modulo unit operands
  assign mod_req.start   = mod_go;
  assign mod_req.value   = (state == S_MODX) ? INT_BITS'(cmd_q.sample_x >>> FRAC_BITS)
                                             : INT_BITS'(cmd_q.sample_y >>> FRAC_BITS);
  assign mod_req.divisor = dim_sel;
  assign dim_sel         = (state == S_MODX) ? w_eff : h_eff;
  assign inc             = {1'b0, mod_rsp.rem} + 1'b1;

  bwts_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // address generation
  always_comb begin
    ax = k[0] ? x1 : x0;
    ay = k[1] ? y1 : y0;
    prod = (ADDR_BITS+1)'(ay * w_eff) + (ADDR_BITS+1)'(ax);
    addr = prod[ADDR_BITS-1:0];
    we   = (state == S_WR);
    wdata.r = cmd_q.red_in;
    wdata.g = cmd_q.green_in;
    wdata.b = cmd_q.blue_in;
  end

  bwts_store u_store (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // blend operand select
  always_comb begin
    case (ph)
      2'd0: begin
        la = LERP_W'(chan_of(tex[0], chan));
        lb = LERP_W'(chan_of(tex[1], chan));
        lf = cmd_q.sample_x[FRAC_BITS-1:0];
      end
      2'd1: begin
        la = LERP_W'(chan_of(tex[2], chan));
        lb = LERP_W'(chan_of(tex[3], chan));
        lf = cmd_q.sample_x[FRAC_BITS-1:0];
      end
      default: begin
        la = top;
        lb = lsum[LERP_W-1:0];
        lf = cmd_q.sample_y[FRAC_BITS-1:0];
      end
    endcase
    rnd = {1'b0, lsum} + (SUM_W+1)'(1 << (2 * FRAC_BITS - 1));
  end

  bwts_lerp u_lerp (
    .clk (clk),
    .a   (la),
    .b   (lb),
    .f   (lf),
    .sum (lsum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mod_go <= 1'b0;
      lv     <= 1'b0;
      k      <= '0;
      chan   <= '0;
      ph     <= '0;
    end else begin
      mod_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            x0    <= cmd.pix_x;
            y0    <= cmd.pix_y;
            k     <= '0;
            unique case (cmd.op)
              OP_WRITE:  state <= S_WR;
              OP_READ:   state <= S_RD;
              OP_SAMPLE: begin
                state  <= S_MODX;
                mod_go <= 1'b1;
              end
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_WR: state <= S_IDLE;
        S_MODX: begin
          if (mod_rsp.done) begin
            x0     <= mod_rsp.rem;
            x1     <= (inc == w_eff) ? '0 : inc[PIX_BITS-1:0];
            state  <= S_MODY;
            mod_go <= 1'b1;
          end
        end
        S_MODY: begin
          if (mod_rsp.done) begin
            y0    <= mod_rsp.rem;
            y1    <= (inc == h_eff) ? '0 : inc[PIX_BITS-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          if (k != 3'd0) tex[k[1:0] - 2'd1] <= rdata;
          k <= k + 1'b1;
          if (k == nreads) begin
            chan  <= '0;
            ph    <= '0;
            lv    <= 1'b0;
            state <= (cmd_q.op == OP_SAMPLE) ? S_LERP : S_DONE;
          end
        end
        S_LERP: begin
          if (lv) begin
            if (last_ph == 2'd0) top <= lsum[LERP_W-1:0];
            if (last_ph == 2'd2) res[last_chan] <= rnd[SUM_W-1:2*FRAC_BITS];
          end
          if (chan != 2'd3) begin
            lv        <= 1'b1;
            last_ph   <= ph;
            last_chan <= chan;
            if (ph == 2'd2) begin
              ph   <= '0;
              chan <= chan + 1'b1;
            end else begin
              ph <= ph + 1'b1;
            end
          end else begin
            lv    <= 1'b0;
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done = (state == S_DONE);

  always_comb begin
    if (cmd_q.op == OP_SAMPLE) begin
      result.red_out   = res[0];
      result.green_out = res[1];
      result.blue_out  = res[2];
    end else begin
      result.red_out   = tex[0].r;
      result.green_out = tex[0].g;
      result.blue_out  = tex[0].b;
    end
  end

  `BWTS_ASSERT_NOW(a_done_while_busy, done, busy)
  `BWTS_ASSERT_NEXT(a_done_single, done, !done)
  `BWTS_ASSERT_NEXT(a_accept_busy, start && !busy && cmd.op != OP_NONE, busy)

endmodule
